/* design/ffrq_pkg.sv */
// shared types and constants for the fifo frame replacement queue
// used by every module of the block; depends on nothing
package ffrq_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 6;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;

  // search grouping: cells are scanned in groups of GROUP
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (NUM_FRAMES + GROUP - 1) / GROUP;
  localparam int PAD_SLOTS  = NUM_GROUPS * GROUP;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_PAGE   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_RESOLVE,
    ST_APPLY
  } state_t;

  // request as seen by every cell
  typedef struct packed {
    logic               victim;
    logic [FRAME_W-1:0] frame_id;
    logic               is_page;
  } match_t;

  // queue update strobes
  typedef struct packed {
    logic append;
    logic drop;
  } cell_ctl_t;

  // search pipeline enables
  typedef struct packed {
    logic cmp_en;
    logic scan_en;
    logic resolve_en;
  } scan_ctl_t;

endpackage

/* design/fifo_frame_replacement_queue_core.sv */
// Frame replacement queue: keeps frames in arrival order in a row of slot
// cells. Add appends a frame at the tail, victim removes the oldest frame
// that holds a page, remove deletes a named frame and closes the gap.
//
// Input channel s_*: one request item per handshake. Output channel m_*:
// exactly one result item per request, in request order.
// A request is taken in the idle state; the cells compare in the match
// state, the two-stage search over cell groups runs in the scan and
// resolve states, and the update plus result register load happen in the
// apply state. The result shows on m_tvalid once apply has loaded the
// output register, and a new request is taken only back in idle, so one
// request is in flight at a time; an output stall holds the apply state.
// A result held in the output register does not block the next request;
// if the receiver still stalls when the next result is ready, the update
// and that result wait until the output register is free.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// Depends on ffrq_pkg, ffrq_cell, ffrq_scan and ffrq_ctrl.
module fifo_frame_replacement_queue_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [5:0] frame_id, [7:6] zero
  input  logic [2:0] s_tuser,  // [1:0] func, [2] frame_is_page
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [5:0] result_frame, [7:6] zero
  output logic [2:0] m_tuser   // [2:0] status
);

  ffrq_pkg::match_t    mcmd;
  ffrq_pkg::cell_ctl_t ctl;
  ffrq_pkg::scan_ctl_t sctl;

  logic [ffrq_pkg::FRAME_W-1:0]    cell_frame [ffrq_pkg::NUM_FRAMES];
  logic [ffrq_pkg::NUM_FRAMES-1:0] cell_valid;
  logic [ffrq_pkg::NUM_FRAMES-1:0] cell_page;
  logic [ffrq_pkg::NUM_FRAMES-1:0] cell_hit;
  logic [ffrq_pkg::NUM_FRAMES-1:0] kill;
  logic                            found;
  logic [ffrq_pkg::FRAME_W-1:0]    found_frame;
  logic [ffrq_pkg::FRAME_W-1:0]    result_frame;
  logic [ffrq_pkg::STATUS_W-1:0]   status;

  for (genvar i = 0; i < ffrq_pkg::NUM_FRAMES; i++) begin : g_cell
    logic [ffrq_pkg::FRAME_W-1:0] nbr_frame;
    logic                         nbr_valid;
    logic                         nbr_page;
    logic                         prev_valid;

    if (i == ffrq_pkg::NUM_FRAMES - 1) begin : g_last
      assign nbr_frame = '0;
      assign nbr_valid = 1'b0;
      assign nbr_page  = 1'b0;
    end else begin : g_mid
      assign nbr_frame = cell_frame[i+1];
      assign nbr_valid = cell_valid[i+1];
      assign nbr_page  = cell_page[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    ffrq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .mcmd       (mcmd),
      .cmp_en     (sctl.cmp_en),
      .ctl        (ctl),
      .kill       (kill[i]),
      .prev_valid (prev_valid),
      .nbr_frame  (nbr_frame),
      .nbr_valid  (nbr_valid),
      .nbr_page   (nbr_page),
      .frame      (cell_frame[i]),
      .valid      (cell_valid[i]),
      .page       (cell_page[i]),
      .hit        (cell_hit[i])
    );
  end

  ffrq_scan u_scan (
    .clk         (clk),
    .sctl        (sctl),
    .hit         (cell_hit),
    .frames      (cell_frame),
    .kill        (kill),
    .found       (found),
    .found_frame (found_frame)
  );

  ffrq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .req_func     (s_tuser[1:0]),
    .req_frame    (s_tdata[5:0]),
    .req_page     (s_tuser[2]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .result_frame (result_frame),
    .status       (status),
    .found        (found),
    .found_frame  (found_frame),
    .full         (cell_valid[ffrq_pkg::NUM_FRAMES-1]),
    .mcmd         (mcmd),
    .ctl          (ctl),
    .sctl         (sctl)
  );

  assign m_tdata = {2'b00, result_frame};
  assign m_tuser = status;

endmodule

/* design/ffrq_cell.sv */
// one queue slot: holds a frame, its valid and page flags, and a match bit
// shifts in from its upper neighbor on a drop when its kill bit is set; depends on ffrq_pkg
module ffrq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  ffrq_pkg::match_t            mcmd,
  input  logic                        cmp_en,
  input  ffrq_pkg::cell_ctl_t         ctl,
  input  logic                        kill,
  input  logic                        prev_valid,
  input  logic [ffrq_pkg::FRAME_W-1:0] nbr_frame,
  input  logic                        nbr_valid,
  input  logic                        nbr_page,
  output logic [ffrq_pkg::FRAME_W-1:0] frame,
  output logic                        valid,
  output logic                        page,
  output logic                        hit
);

  logic tail;
  logic take_nbr;
  logic take_new;

  // first free slot sits right behind the last occupied one
  assign tail     = prev_valid & ~valid;
  assign take_nbr = ctl.drop & kill;
  assign take_new = ctl.append & tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      page  <= 1'b0;
    end else begin
      if (take_nbr) begin
        valid <= nbr_valid;
        page  <= nbr_page;
      end else if (take_new) begin
        valid <= 1'b1;
        page  <= mcmd.is_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_nbr) begin
      frame <= nbr_frame;
    end else if (take_new) begin
      frame <= mcmd.frame_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit <= valid & (mcmd.victim ? page : (frame == mcmd.frame_id));
    end
  end

endmodule

/* design/ffrq_scan.sv */
// two-stage search over the cell match bits: first hit, prefix mask, frame
// groups of ffrq_pkg::GROUP cells are resolved first, then across groups
module ffrq_scan (
  input  logic                         clk,
  input  ffrq_pkg::scan_ctl_t          sctl,
  input  logic [ffrq_pkg::NUM_FRAMES-1:0] hit,
  input  logic [ffrq_pkg::FRAME_W-1:0] frames [ffrq_pkg::NUM_FRAMES],
  output logic [ffrq_pkg::NUM_FRAMES-1:0] kill,
  output logic                         found,
  output logic [ffrq_pkg::FRAME_W-1:0] found_frame
);

  logic [ffrq_pkg::PAD_SLOTS-1:0]  hit_pad;
  logic [ffrq_pkg::FRAME_W-1:0]    frames_pad [ffrq_pkg::PAD_SLOTS];
  logic [ffrq_pkg::PAD_SLOTS-1:0]  pre_c, pre_q;
  logic [ffrq_pkg::NUM_GROUPS-1:0] grp_any_c, grp_any_q;
  logic [ffrq_pkg::FRAME_W-1:0]    grp_frame_c [ffrq_pkg::NUM_GROUPS];
  logic [ffrq_pkg::FRAME_W-1:0]    grp_frame_q [ffrq_pkg::NUM_GROUPS];
  logic [ffrq_pkg::PAD_SLOTS-1:0]  kill_c, kill_q;
  logic                            found_c;
  logic [ffrq_pkg::FRAME_W-1:0]    frame_c;

  always_comb begin
    hit_pad = '0;
    hit_pad[ffrq_pkg::NUM_FRAMES-1:0] = hit;
    for (int i = 0; i < ffrq_pkg::PAD_SLOTS; i++) begin
      frames_pad[i] = (i < ffrq_pkg::NUM_FRAMES) ? frames[i] : '0;
    end
  end

  // stage one: inclusive prefix inside each group
  always_comb begin
    logic                         run;
    logic [ffrq_pkg::FRAME_W-1:0] fr;
    for (int g = 0; g < ffrq_pkg::NUM_GROUPS; g++) begin
      run = 1'b0;
      fr  = '0;
      for (int k = 0; k < ffrq_pkg::GROUP; k++) begin
        // only the first hit of the group supplies its frame
        if (hit_pad[g*ffrq_pkg::GROUP + k] && !run) begin
          fr = frames_pad[g*ffrq_pkg::GROUP + k];
        end
        run = run | hit_pad[g*ffrq_pkg::GROUP + k];
        pre_c[g*ffrq_pkg::GROUP + k] = run;
      end
      grp_any_c[g]   = run;
      grp_frame_c[g] = fr;
    end
  end

  always_ff @(posedge clk) begin
    if (sctl.scan_en) begin
      pre_q     <= pre_c;
      grp_any_q <= grp_any_c;
      for (int g = 0; g < ffrq_pkg::NUM_GROUPS; g++) begin
        grp_frame_q[g] <= grp_frame_c[g];
      end
    end
  end

  // stage two: carry hits of earlier groups into later ones
  always_comb begin
    logic seen;
    seen    = 1'b0;
    frame_c = '0;
    for (int g = 0; g < ffrq_pkg::NUM_GROUPS; g++) begin
      for (int k = 0; k < ffrq_pkg::GROUP; k++) begin
        kill_c[g*ffrq_pkg::GROUP + k] = pre_q[g*ffrq_pkg::GROUP + k] | seen;
      end
      // first hitting group supplies the frame
      frame_c = frame_c | ((grp_any_q[g] & ~seen) ? grp_frame_q[g] : '0);
      seen    = seen | grp_any_q[g];
    end
    found_c = seen;
  end

  always_ff @(posedge clk) begin
    if (sctl.resolve_en) begin
      kill_q      <= kill_c;
      found       <= found_c;
      found_frame <= frame_c;
    end
  end

  assign kill = kill_q[ffrq_pkg::NUM_FRAMES-1:0];

endmodule

/* design/ffrq_ctrl.sv */
// sequencer: takes one request, steps the search, applies the update and
// holds the result in an output register; depends on ffrq_pkg
module ffrq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffrq_pkg::FUNC_W-1:0]   req_func,
  input  logic [ffrq_pkg::FRAME_W-1:0]  req_frame,
  input  logic                          req_page,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffrq_pkg::FRAME_W-1:0]  result_frame,
  output logic [ffrq_pkg::STATUS_W-1:0] status,
  input  logic                          found,
  input  logic [ffrq_pkg::FRAME_W-1:0]  found_frame,
  input  logic                          full,
  output ffrq_pkg::match_t              mcmd,
  output ffrq_pkg::cell_ctl_t           ctl,
  output ffrq_pkg::scan_ctl_t           sctl
);

  ffrq_pkg::state_t state, state_next;

  logic [ffrq_pkg::FUNC_W-1:0]   func;
  logic                          fire;
  logic                          out_free;
  logic [ffrq_pkg::FRAME_W-1:0]  res_frame;
  logic [ffrq_pkg::STATUS_W-1:0] res_status;
  logic                          do_append;
  logic                          do_drop;

  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffrq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ffrq_pkg::ST_IDLE:    if (s_tvalid) state_next = ffrq_pkg::ST_MATCH;
      ffrq_pkg::ST_MATCH:   state_next = ffrq_pkg::ST_SCAN;
      ffrq_pkg::ST_SCAN:    state_next = ffrq_pkg::ST_RESOLVE;
      ffrq_pkg::ST_RESOLVE: state_next = ffrq_pkg::ST_APPLY;
      ffrq_pkg::ST_APPLY:   if (out_free) state_next = ffrq_pkg::ST_IDLE;
      default:              state_next = ffrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    sctl.cmp_en     = 1'b0;
    sctl.scan_en    = 1'b0;
    sctl.resolve_en = 1'b0;
    fire            = 1'b0;
    unique case (state)
      ffrq_pkg::ST_IDLE:    s_tready = 1'b1;
      ffrq_pkg::ST_MATCH:   sctl.cmp_en = 1'b1;
      ffrq_pkg::ST_SCAN:    sctl.scan_en = 1'b1;
      ffrq_pkg::ST_RESOLVE: sctl.resolve_en = 1'b1;
      ffrq_pkg::ST_APPLY:   fire = out_free;
      default:              s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func          <= req_func;
      mcmd.victim   <= (req_func == ffrq_pkg::FUNC_VICTIM);
      mcmd.frame_id <= req_frame;
      mcmd.is_page  <= req_page;
    end
  end

  // outcome of the request once the search has settled
  always_comb begin
    res_frame  = '0;
    res_status = ffrq_pkg::STAT_OK;
    do_append  = 1'b0;
    do_drop    = 1'b0;
    unique case (func)
      ffrq_pkg::FUNC_ADD: begin
        priority if (found) begin
          res_status = ffrq_pkg::STAT_DUPLICATE;
        end else if (full) begin
          res_status = ffrq_pkg::STAT_FULL;
        end else begin
          do_append = 1'b1;
          res_frame = mcmd.frame_id;
        end
      end
      ffrq_pkg::FUNC_VICTIM: begin
        if (found) begin
          do_drop   = 1'b1;
          res_frame = found_frame;
        end else begin
          res_status = ffrq_pkg::STAT_NO_PAGE;
        end
      end
      ffrq_pkg::FUNC_REMOVE: begin
        if (found) begin
          do_drop   = 1'b1;
          res_frame = mcmd.frame_id;
        end else begin
          res_status = ffrq_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        res_status = ffrq_pkg::STAT_OK;
      end
    endcase
  end

  assign ctl.append = fire & do_append;
  assign ctl.drop   = fire & do_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_frame <= res_frame;
      status       <= res_status;
    end
  end

endmodule

/* design/ffrq_checker.sv */
// port-level checks for the frame replacement queue
// bound to fifo_frame_replacement_queue_core; depends on ffrq_pkg
module ffrq_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ffrq_pkg::STAT_OK || m_tuser == ffrq_pkg::STAT_NO_PAGE ||
                 m_tuser == ffrq_pkg::STAT_NOT_FOUND ||
                 m_tuser == ffrq_pkg::STAT_DUPLICATE || m_tuser == ffrq_pkg::STAT_FULL)
    else $error("undefined status code");

  // an error result carries frame zero
  a_error_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ffrq_pkg::STAT_OK |-> m_tdata == 8'd0)
    else $error("error result with nonzero frame");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind fifo_frame_replacement_queue_core ffrq_checker u_ffrq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench for fifo_frame_replacement_queue_core: directed table, then random phases
// keeps its own model of the frame queue; depends on ffrq_pkg and the core rtl
module tb;
  import ffrq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               page;
  } queued_frame_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [FRAME_W-1:0]  frame;
    logic                page;
    logic                typed;
    logic [FRAME_W-1:0]  exp_frame;
    logic [STATUS_W-1:0] exp_status;
  } step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;  // [5:0] frame_id, [7:6] zero
  logic [2:0] s_tuser = '0;  // [1:0] func, [2] frame_is_page
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;       // [5:0] result_frame, [7:6] zero
  logic [2:0] m_tuser;       // [2:0] status

  queued_frame_t frame_order[$];
  outcome_t      awaited_results[$];
  outcome_t      oldest_result;
  int            errors = 0;
  int            idle_cycles = 0;
  bit            sender_calm = 1'b0;

  // directed table; typed rows carry a result readable at a glance
  step_t directed_steps[22] = '{
    '{FUNC_VICTIM, 6'd0,  1'b0, 1'b1, 6'd0,  STAT_NO_PAGE},    // empty queue
    '{FUNC_REMOVE, 6'd5,  1'b1, 1'b1, 6'd0,  STAT_NOT_FOUND},
    '{FUNC_UNUSED, 6'd63, 1'b1, 1'b1, 6'd0,  STAT_OK},
    '{FUNC_ADD,    6'd0,  1'b1, 1'b1, 6'd0,  STAT_OK},
    '{FUNC_ADD,    6'd63, 1'b0, 1'b1, 6'd63, STAT_OK},
    '{FUNC_ADD,    6'd63, 1'b1, 1'b1, 6'd0,  STAT_DUPLICATE},
    '{FUNC_ADD,    6'd0,  1'b0, 1'b1, 6'd0,  STAT_DUPLICATE},
    '{FUNC_ADD,    6'd21, 1'b0, 1'b1, 6'd21, STAT_OK},
    '{FUNC_ADD,    6'd42, 1'b1, 1'b1, 6'd42, STAT_OK},
    '{FUNC_VICTIM, 6'd63, 1'b1, 1'b1, 6'd0,  STAT_OK},         // oldest page frame
    '{FUNC_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0,  STAT_OK},         // skips non-page frames
    '{FUNC_VICTIM, 6'd42, 1'b0, 1'b0, 6'd0,  STAT_OK},         // only non-page frames left
    '{FUNC_REMOVE, 6'd21, 1'b0, 1'b0, 6'd0,  STAT_OK},
    '{FUNC_REMOVE, 6'd21, 1'b0, 1'b1, 6'd0,  STAT_NOT_FOUND},
    '{FUNC_ADD,    6'd10, 1'b1, 1'b0, 6'd0,  STAT_OK},
    '{FUNC_ADD,    6'd11, 1'b1, 1'b0, 6'd0,  STAT_OK},
    '{FUNC_REMOVE, 6'd63, 1'b1, 1'b0, 6'd0,  STAT_OK},         // head
    '{FUNC_REMOVE, 6'd11, 1'b0, 1'b0, 6'd0,  STAT_OK},         // tail
    '{FUNC_VICTIM, 6'd33, 1'b1, 1'b0, 6'd0,  STAT_OK},
    '{FUNC_UNUSED, 6'd0,  1'b0, 1'b1, 6'd0,  STAT_OK},
    '{FUNC_ADD,    6'd42, 1'b1, 1'b0, 6'd0,  STAT_OK},
    '{FUNC_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0,  STAT_OK}
  };

  fifo_frame_replacement_queue_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int locate_frame(logic [FRAME_W-1:0] frame);
    for (int i = 0; i < frame_order.size(); i++) begin
      if (frame_order[i].frame == frame) return i;
    end
    return -1;
  endfunction

  // applies one request to the queue copy and returns the result it gives
  function automatic outcome_t queue_outcome(logic [FUNC_W-1:0] func,
                                             logic [FRAME_W-1:0] frame, logic page);
    outcome_t r;
    int       pos;
    r = '0;
    r.status = STAT_OK;
    case (func)
      FUNC_ADD: begin
        if (locate_frame(frame) >= 0) begin
          r.status = STAT_DUPLICATE;
        end else if (frame_order.size() >= NUM_FRAMES) begin
          r.status = STAT_FULL;
        end else begin
          frame_order.push_back('{frame: frame, page: page});
          r.frame = frame;
        end
      end
      FUNC_VICTIM: begin
        pos = -1;
        for (int i = 0; i < frame_order.size() && pos < 0; i++) begin
          if (frame_order[i].page) pos = i;
        end
        if (pos < 0) begin
          r.status = STAT_NO_PAGE;
        end else begin
          r.frame = frame_order[pos].frame;
          frame_order.delete(pos);
        end
      end
      FUNC_REMOVE: begin
        pos = locate_frame(frame);
        if (pos < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          frame_order.delete(pos);
          r.frame = frame;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FRAME_W-1:0] queued_pick();
    if (frame_order.size() == 0) return FRAME_W'($urandom_range(0, 63));
    return frame_order[$urandom_range(0, frame_order.size() - 1)].frame;
  endfunction

  function automatic logic [FRAME_W-1:0] free_pick();
    logic [FRAME_W-1:0] start;
    start = FRAME_W'($urandom_range(0, 63));
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (locate_frame(start + i[FRAME_W-1:0]) < 0) return start + i[FRAME_W-1:0];
    end
    return start;
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] func, logic [FRAME_W-1:0] frame, logic page,
                           logic typed, outcome_t typed_result);
    outcome_t predicted;
    int       gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, frame};
    s_tuser  <= {page, func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = queue_outcome(func, frame, page);
    awaited_results.push_back(typed ? typed_result : predicted);
    gap = sender_calm ? 0 : pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: compare each item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result with none expected: result_frame %0d status %0d",
               m_tdata[5:0], m_tuser);
        errors++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (m_tdata[5:0] !== oldest_result.frame) begin
          $error("result_frame: expected %0d, got %0d", oldest_result.frame, m_tdata[5:0]);
          errors++;
        end
        if (m_tuser !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls
  initial begin : rx_stalls
    int n;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else begin
        n = pause_len();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                 sent;
    int                 mode;
    int                 phase_len;
    int                 page_bias;
    int                 r;
    logic [FUNC_W-1:0]  func;
    logic [FRAME_W-1:0] frame;
    logic               page;
    outcome_t           typed_result;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      typed_result.frame  = directed_steps[i].exp_frame;
      typed_result.status = directed_steps[i].exp_status;
      send_item(directed_steps[i].func, directed_steps[i].frame, directed_steps[i].page,
                directed_steps[i].typed, typed_result);
    end

    // phases: fill toward a full queue, drain it, or mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode        = $urandom_range(0, 2);
      phase_len   = $urandom_range(20, 120);
      page_bias   = $urandom_range(10, 90);
      sender_calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       func = (r < 82) ? FUNC_ADD : (r < 90) ? FUNC_VICTIM :
                          (r < 98) ? FUNC_REMOVE : FUNC_UNUSED;
          1:       func = (r < 15) ? FUNC_ADD : (r < 62) ? FUNC_VICTIM :
                          (r < 98) ? FUNC_REMOVE : FUNC_UNUSED;
          default: func = (r < 40) ? FUNC_ADD : (r < 68) ? FUNC_VICTIM :
                          (r < 96) ? FUNC_REMOVE : FUNC_UNUSED;
        endcase
        frame = FRAME_W'($urandom_range(0, 63));
        page  = 1'($urandom_range(0, 1));
        if (func == FUNC_ADD) begin
          frame = ($urandom_range(0, 9) == 0) ? queued_pick() : free_pick();
          page  = ($urandom_range(0, 99) < page_bias);
        end else if (func == FUNC_REMOVE && $urandom_range(0, 4) != 0) begin
          frame = queued_pick();
        end
        typed_result = '0;
        send_item(func, frame, page, 1'b0, typed_result);
        sent++;
      end
    end
    sender_calm = 1'b0;
    s_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
